@@ hdl/pe_signature_tag_locator_defines.svh @@
// Assertion macros for the signature tag locator.
// Included by the top level; relies on clk and arst_n in the including scope.
`ifndef PE_SIGNATURE_TAG_LOCATOR_DEFINES_SVH
`define PE_SIGNATURE_TAG_LOCATOR_DEFINES_SVH

// Same-cycle implication.
`define PESIG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PESIG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/pesig_pkg.sv @@
// Shared constants and types for the signature tag locator.
// No dependencies; used by the core, the top level and the testbench.
package pesig_pkg;

	localparam logic [15:0] MZ_MAGIC         = 16'h5A4D;
	localparam logic [15:0] ASN1_MAGIC       = 16'h8230;
	localparam logic [31:0] HEADER_FIELD_END = 32'd63;  // last byte of header offset
	localparam logic [31:0] CERT_ADDR_END    = 32'd155; // header + 152 + 3
	localparam logic [31:0] CERT_LEN_END     = 32'd159; // header + 156 + 3
	localparam logic [31:0] ASN1_HDR_END     = 32'd11;  // address + 8 + 3
	localparam logic [31:0] SIZE_PAD_ADD     = 32'd19;
	localparam logic [31:0] PAD_MASK         = 32'h0FFFFFF8;

	localparam int MAX_TAG_BYTES = 2048;
	localparam int TAG_LEN_W     = 12;
	localparam int CLAMP_W       = $clog2(MAX_TAG_BYTES + 1);
	localparam int TLEN_W        = (CLAMP_W > TAG_LEN_W) ? CLAMP_W : TAG_LEN_W;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;
	localparam logic [CFG_INDEX_W-1:0] REG_FILE_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TAG_LENGTH  = 2'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_byte;
	} pesig_item_t;

	typedef struct packed {
		logic [31:0] tag_offset;
		logic        tag_found;
		logic        not_executable;
	} pesig_result_t;

endpackage

@@ hdl/pesig_if.sv @@
// Request channels of the signature tag locator: byte stream in, result out.
// Depends on nothing; its field widths match the structs of pesig_pkg.
interface pesig_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, output data_byte, output first_byte, input ready);
	modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface

interface pesig_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] tag_offset;
	logic        tag_found;
	logic        not_executable;

	modport source (output valid, output tag_offset, output tag_found,
		output not_executable, input ready);
	modport sink (input valid, input tag_offset, input tag_found,
		input not_executable, output ready);
endinterface

@@ hdl/pesig_core.sv @@
// Capture state and next-state logic of the signature tag locator.
// Depends on pesig_pkg. The state registers double as the result register.
module pesig_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  pesig_pkg::pesig_item_t              item,
	input  logic [31:0]                         file_length,
	input  logic [pesig_pkg::TAG_LEN_W-1:0]     tag_length,
	output pesig_pkg::pesig_result_t            result
);

	typedef enum logic [1:0] {
		MAGIC_UNKNOWN = 2'd0,
		MAGIC_VALID   = 2'd1,
		MAGIC_INVALID = 2'd2
	} magic_t;

	logic [31:0] byte_pos_q, shift_q, hdr_pos_q, cert_addr_q, found_off_q;
	logic        hdr_known_q, cert_known_q, found_q;
	magic_t      magic_q;

	logic [31:0] byte_pos_d, shift_d, hdr_pos_d, cert_addr_d, found_off_d;
	logic        hdr_known_d, cert_known_d, found_d;
	magic_t      magic_d;

	logic [pesig_pkg::TLEN_W-1:0] tlen;

	always_comb begin
		if (pesig_pkg::TLEN_W'(tag_length) > pesig_pkg::TLEN_W'(pesig_pkg::MAX_TAG_BYTES))
			tlen = pesig_pkg::TLEN_W'(pesig_pkg::MAX_TAG_BYTES);
		else
			tlen = pesig_pkg::TLEN_W'(tag_length);
	end

	// Fields are tested in order magic, header, address, length, ASN.1 header;
	// each test sees what earlier ones captured on the same byte.
	always_comb begin
		logic [31:0] pos;
		logic [31:0] word;
		logic [15:0] size;
		logic [31:0] total;
		logic        bad_magic;
		pos          = item.first_byte ? 32'd0 : byte_pos_q;
		word         = {item.data_byte, (item.first_byte ? 24'd0 : shift_q[31:8])};
		magic_d      = item.first_byte ? MAGIC_UNKNOWN : magic_q;
		hdr_pos_d    = item.first_byte ? 32'd0 : hdr_pos_q;
		hdr_known_d  = item.first_byte ? 1'b0 : hdr_known_q;
		cert_addr_d  = item.first_byte ? 32'd0 : cert_addr_q;
		cert_known_d = item.first_byte ? 1'b0 : cert_known_q;
		found_off_d  = item.first_byte ? 32'd0 : found_off_q;
		found_d      = item.first_byte ? 1'b0 : found_q;
		bad_magic    = 1'b0;
		size         = {word[23:16], word[31:24]};
		total        = (32'(size) + pesig_pkg::SIZE_PAD_ADD) & pesig_pkg::PAD_MASK;

		if (pos == 32'd1) begin
			if (word[31:16] != pesig_pkg::MZ_MAGIC) begin
				magic_d   = MAGIC_INVALID;
				bad_magic = 1'b1;
			end else begin
				magic_d = MAGIC_VALID;
			end
		end

		if (!bad_magic) begin
			if (magic_d == MAGIC_VALID && pos == pesig_pkg::HEADER_FIELD_END
					&& word != 32'd0) begin
				hdr_pos_d   = word;
				hdr_known_d = 1'b1;
			end
			if (hdr_known_d) begin
				if (pos == hdr_pos_d + pesig_pkg::CERT_ADDR_END && word != 32'd0) begin
					cert_addr_d  = word;
					cert_known_d = 1'b1;
				end
				if (pos == hdr_pos_d + pesig_pkg::CERT_LEN_END && word == 32'd0)
					cert_known_d = 1'b0;
			end
			if (cert_known_d && pos == cert_addr_d + pesig_pkg::ASN1_HDR_END
					&& word[15:0] == pesig_pkg::ASN1_MAGIC) begin
				found_off_d = cert_addr_d + total;
				// fit test is done without wrap
				if ({1'b0, found_off_d} + 33'(tlen) <= {1'b0, file_length})
					found_d = 1'b1;
			end
		end

		shift_d    = word;
		byte_pos_d = pos + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_pos_q   <= '0;
			shift_q      <= '0;
			magic_q      <= MAGIC_UNKNOWN;
			hdr_pos_q    <= '0;
			hdr_known_q  <= 1'b0;
			cert_addr_q  <= '0;
			cert_known_q <= 1'b0;
			found_off_q  <= '0;
			found_q      <= 1'b0;
		end else if (step) begin
			byte_pos_q   <= byte_pos_d;
			shift_q      <= shift_d;
			magic_q      <= magic_d;
			hdr_pos_q    <= hdr_pos_d;
			hdr_known_q  <= hdr_known_d;
			cert_addr_q  <= cert_addr_d;
			cert_known_q <= cert_known_d;
			found_off_q  <= found_off_d;
			found_q      <= found_d;
		end
	end

	assign result.tag_offset     = found_off_q;
	assign result.tag_found      = found_q;
	assign result.not_executable = (magic_q == MAGIC_INVALID);

endmodule

@@ hdl/pe_signature_tag_locator.sv @@
// Signature tag locator: streams an executable one byte per request.
// An accepted byte is held in the input stage register, then its result lands in the result register.
// Throughput: one byte per cycle while results are drained; capture state updates once per byte.
// Stalls only when the input stage and the result register are full and the result waits.
// arst_n clears all capture state, the registers file_length/tag_length and valids.
// Depends on pesig_pkg, pesig_if.sv, pesig_core.sv and the assertion macro header.
`include "pe_signature_tag_locator_defines.svh"

module pe_signature_tag_locator (
	input  logic                               clk,
	input  logic                               arst_n,
	pesig_byte_if.sink                         byte_ch,
	pesig_result_if.source                     result_ch,
	input  logic                               wr_en,
	input  logic [pesig_pkg::CFG_INDEX_W-1:0]  wr_index,
	input  logic [pesig_pkg::CFG_DATA_W-1:0]   wr_data
);

	logic [31:0]                        file_length_q;
	logic [pesig_pkg::TAG_LEN_W-1:0]    tag_length_q;
	logic                               valid_s1;
	pesig_pkg::pesig_item_t             item_s1;
	logic                               out_valid_q;
	logic                               advance;
	pesig_pkg::pesig_result_t           result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			tag_length_q  <= '0;
		end else if (wr_en) begin
			case (wr_index)
				pesig_pkg::REG_FILE_LENGTH: file_length_q <= wr_data[31:0];
				pesig_pkg::REG_TAG_LENGTH:  tag_length_q  <= wr_data[pesig_pkg::TAG_LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves into the result register when that is empty or being drained
	assign advance       = valid_s1 && (!out_valid_q || result_ch.ready);
	assign byte_ch.ready = !valid_s1 || !out_valid_q || result_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.valid && byte_ch.ready) begin
			item_s1.data_byte  <= byte_ch.data_byte;
			item_s1.first_byte <= byte_ch.first_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	pesig_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.item        (item_s1),
		.file_length (file_length_q),
		.tag_length  (tag_length_q),
		.result      (result)
	);

	assign result_ch.valid          = out_valid_q;
	assign result_ch.tag_offset     = result.tag_offset;
	assign result_ch.tag_found      = result.tag_found;
	assign result_ch.not_executable = result.not_executable;

	`PESIG_ASSERT_NOW(a_stall_only_when_full, !byte_ch.ready, valid_s1 && out_valid_q, "input stalled with room in the pipeline")
	`PESIG_ASSERT_NEXT(a_s1_holds, valid_s1 && !advance, valid_s1 && $stable(item_s1), "stage 1 lost its byte while blocked")
	`PESIG_ASSERT_NEXT(a_state_only_on_step, !advance, $stable(result), "capture state changed without a byte moving")

endmodule

@@ dv/tb.sv @@
// Testbench for pe_signature_tag_locator: streams built and random executables byte by byte
// and checks every result against an in-bench model of the tag search.
// Depends on pesig_pkg, pesig_if.sv and the RTL top level.
module tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [pesig_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [pesig_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	typedef enum logic [1:0] {
		MAGIC_UNKNOWN,
		MAGIC_VALID,
		MAGIC_INVALID
	} magic_state_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [pesig_pkg::CFG_INDEX_W-1:0] wr_index;
	logic [pesig_pkg::CFG_DATA_W-1:0] wr_data;

	pesig_byte_if byte_ch();
	pesig_result_if result_ch();

	pe_signature_tag_locator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_ch(byte_ch),
		.result_ch(result_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// model of the locator
	logic [31:0] file_len_cfg = '0;
	logic [pesig_pkg::TAG_LEN_W-1:0] tag_len_cfg = '0;
	logic [31:0] byte_pos = '0;
	logic [31:0] shift_word = '0;
	magic_state_t magic = MAGIC_UNKNOWN;
	logic [31:0] hdr_pos = '0;
	logic hdr_known = 1'b0;
	logic [31:0] table_addr = '0;
	logic table_known = 1'b0;
	logic [31:0] tag_ofs = '0;
	logic tag_hit = 1'b0;

	pesig_pkg::pesig_result_t pending_results[$];
	int mismatch_count = 0;
	int bytes_sent = 0;
	bit src_idle = 1'b1;
	bit snk_idle = 1'b1;
	logic [7:0] file_img[];

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("pe_signature_tag_locator verification failed");
		$finish;
	end

	function automatic pesig_pkg::pesig_result_t locate_tag(input logic [7:0] value,
			input logic restart);
		logic [31:0] pos;
		logic [31:0] padded;
		logic [31:0] tlen;
		pesig_pkg::pesig_result_t res;
		if (restart) begin
			byte_pos = '0;
			shift_word = '0;
			magic = MAGIC_UNKNOWN;
			hdr_pos = '0;
			hdr_known = 1'b0;
			table_addr = '0;
			table_known = 1'b0;
			tag_ofs = '0;
			tag_hit = 1'b0;
		end
		pos = byte_pos;
		shift_word = {value, shift_word[31:8]};
		if (pos == 32'd1)
			magic = (shift_word[31:16] == pesig_pkg::MZ_MAGIC) ? MAGIC_VALID : MAGIC_INVALID;
		// a failed magic check ends all work on this byte
		if (!(pos == 32'd1 && magic == MAGIC_INVALID)) begin
			if (magic == MAGIC_VALID && pos == pesig_pkg::HEADER_FIELD_END
					&& shift_word != '0) begin
				hdr_pos = shift_word;
				hdr_known = 1'b1;
			end
			if (hdr_known) begin
				if (pos == hdr_pos + pesig_pkg::CERT_ADDR_END && shift_word != '0) begin
					table_addr = shift_word;
					table_known = 1'b1;
				end
				if (pos == hdr_pos + pesig_pkg::CERT_LEN_END && shift_word == '0)
					table_known = 1'b0;
			end
			if (table_known && pos == table_addr + pesig_pkg::ASN1_HDR_END
					&& shift_word[15:0] == pesig_pkg::ASN1_MAGIC) begin
				padded = ({16'h0, shift_word[23:16], shift_word[31:24]}
					+ pesig_pkg::SIZE_PAD_ADD) & pesig_pkg::PAD_MASK;
				tlen = (tag_len_cfg > pesig_pkg::MAX_TAG_BYTES) ? pesig_pkg::MAX_TAG_BYTES
					: tag_len_cfg;
				tag_ofs = table_addr + padded;
				if ({1'b0, tag_ofs} + {1'b0, tlen} <= {1'b0, file_len_cfg})
					tag_hit = 1'b1;
			end
		end
		byte_pos = pos + 32'd1;
		res.tag_offset = tag_ofs;
		res.tag_found = tag_hit;
		res.not_executable = (magic == MAGIC_INVALID);
		return res;
	endfunction

	task automatic send_byte(input logic [7:0] value, input logic restart);
		int gap;
		if (src_idle && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 10);
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid <= 1'b1;
		byte_ch.data_byte <= value;
		byte_ch.first_byte <= restart;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		pending_results.push_back(locate_tag(value, restart));
		bytes_sent++;
	endtask

	// result sink with bursty stalls
	initial begin : result_ready_driver
		int stall;
		stall = 0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				stall--;
			end else if (snk_idle && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				stall = $urandom_range(1, 10) - 1;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_checker
		pesig_pkg::pesig_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: tag_offset %0h", result_ch.tag_offset);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (result_ch.tag_offset !== want.tag_offset) begin
					$error("tag_offset expected %0h actual %0h", want.tag_offset,
						result_ch.tag_offset);
					mismatch_count++;
				end
				if (result_ch.tag_found !== want.tag_found) begin
					$error("tag_found expected %0b actual %0b", want.tag_found,
						result_ch.tag_found);
					mismatch_count++;
				end
				if (result_ch.not_executable !== want.not_executable) begin
					$error("not_executable expected %0b actual %0b", want.not_executable,
						result_ch.not_executable);
					mismatch_count++;
				end
			end
		end
	end

	task automatic settle();
		byte_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pesig_pkg::CFG_INDEX_W-1:0] idx,
			input logic [31:0] value);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			pesig_pkg::REG_FILE_LENGTH: file_len_cfg = value;
			pesig_pkg::REG_TAG_LENGTH: tag_len_cfg = value[pesig_pkg::TAG_LEN_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_config(input logic [31:0] flen, input logic [31:0] tlen);
		settle();
		write_reg(pesig_pkg::REG_FILE_LENGTH, flen);
		write_reg(pesig_pkg::REG_TAG_LENGTH, tlen);
		// spare indexes must be ignored
		write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, $urandom);
	endtask

	function automatic void put_le(input logic [31:0] at, input logic [31:0] value,
			input int count);
		logic [31:0] spot;
		for (int k = 0; k < count; k++) begin
			spot = at + k;
			if (spot < file_img.size())
				file_img[spot] = value[8*k +: 8];
		end
	endfunction

	// later fields overwrite earlier ones where they overlap
	function automatic void build_image(input logic [31:0] hdr, input logic [31:0] addr,
			input logic [31:0] len, input logic [15:0] asn, input logic [15:0] size,
			input int nbytes);
		file_img = new[nbytes];
		foreach (file_img[i])
			file_img[i] = $urandom;
		put_le(addr + 32'd8, {16'h0, asn}, 2);
		put_le(addr + 32'd10, {16'h0, size[7:0], size[15:8]}, 2);
		put_le(hdr + pesig_pkg::CERT_LEN_END - 32'd3, len, 4);
		put_le(hdr + pesig_pkg::CERT_ADDR_END - 32'd3, addr, 4);
		put_le(pesig_pkg::HEADER_FIELD_END - 32'd3, hdr, 4);
		put_le(32'd0, {16'h0, pesig_pkg::MZ_MAGIC}, 2);
	endfunction

	task automatic stream_image(input int count, input bit lead_restart, input int restart_odds);
		logic restart;
		for (int i = 0; i < count && i < file_img.size(); i++) begin
			restart = (i == 0) ? lead_restart
				: (restart_odds > 0 && $urandom_range(1, restart_odds) == 1);
			send_byte(file_img[i], restart);
		end
	endtask

	// header offset that puts the end of the table address field at byte 64
	localparam logic [31:0] HDR_SHORT = 32'd64 - pesig_pkg::CERT_ADDR_END;
	localparam logic [31:0] SHORT_OFFSET = 32'd72 + 32'h10010;

	task automatic test_tag_fit();
		// defaults: file length zero, nothing fits
		build_image(HDR_SHORT, 32'd72, 32'd9, pesig_pkg::ASN1_MAGIC, 16'hFFFF, 84);
		stream_image(84, 1'b1, 0);
		// tag length above the maximum is clamped, exact fit
		set_config(SHORT_OFFSET + pesig_pkg::MAX_TAG_BYTES, 32'd4095);
		stream_image(84, 1'b1, 0);
		set_config(SHORT_OFFSET + pesig_pkg::MAX_TAG_BYTES - 1, pesig_pkg::MAX_TAG_BYTES);
		stream_image(84, 1'b1, 0);
		set_config(SHORT_OFFSET, 32'd0);
		stream_image(84, 1'b1, 0);
		set_config(32'hFFFF_FFFF, 32'd4095);
		build_image(HDR_SHORT, 32'd72, 32'd9, pesig_pkg::ASN1_MAGIC, 16'h0000, 84);
		stream_image(84, 1'b1, 0);
	endtask

	task automatic test_magic_check();
		logic [15:0] bad_magic[4];
		bad_magic = '{16'h5B4D, 16'h5A4C, 16'h0000, 16'hFFFF};
		foreach (bad_magic[k]) begin
			build_image(HDR_SHORT, 32'd72, 32'd9, pesig_pkg::ASN1_MAGIC, 16'h0100, 4);
			put_le(32'd0, {16'h0, bad_magic[k]}, 2);
			stream_image(4, 1'b1, 0);
		end
	endtask

	task automatic test_header_fields();
		set_config(32'hFFFF_FFFF, 32'd0);
		// zero header offset is not captured
		build_image(32'd0, 32'd72, 32'd9, pesig_pkg::ASN1_MAGIC, 16'h0040, 84);
		stream_image(84, 1'b1, 0);
		// address field end wraps to a byte already passed
		build_image(32'hFFFF_FF70, 32'd72, 32'd9, pesig_pkg::ASN1_MAGIC, 16'h0040, 84);
		stream_image(84, 1'b1, 0);
		// header offset and table address end on the same byte
		build_image(pesig_pkg::HEADER_FIELD_END - pesig_pkg::CERT_ADDR_END, 32'd72, 32'd9,
			pesig_pkg::ASN1_MAGIC, 16'h0040, 72);
		stream_image(72, 1'b1, 0);
		// zero table address
		build_image(HDR_SHORT, 32'd0, 32'd9, pesig_pkg::ASN1_MAGIC, 16'h0040, 84);
		stream_image(84, 1'b1, 0);
		// zero table length
		build_image(HDR_SHORT, 32'd72, 32'd0, pesig_pkg::ASN1_MAGIC, 16'h0040, 84);
		stream_image(84, 1'b1, 0);
		// ASN.1 bytes swapped
		build_image(HDR_SHORT, 32'd72, 32'd9,
			{pesig_pkg::ASN1_MAGIC[7:0], pesig_pkg::ASN1_MAGIC[15:8]}, 16'h0040, 84);
		stream_image(84, 1'b1, 0);
		// ASN.1 header ends on the last byte of the table length
		build_image(32'd1, 32'd149, 32'h0010_8230, pesig_pkg::ASN1_MAGIC, 16'h0000, 164);
		stream_image(164, 1'b1, 0);
		build_image(32'd1, 32'd170, 32'd5, pesig_pkg::ASN1_MAGIC, 16'h0001, 184);
		stream_image(184, 1'b1, 0);
	endtask

	task automatic test_restart();
		build_image(HDR_SHORT, 32'd72, 32'd9, pesig_pkg::ASN1_MAGIC, 16'h0123, 84);
		stream_image(40, 1'b1, 0);
		stream_image(84, 1'b1, 0);
		// new file announced without a restart flag continues the old count
		stream_image(20, 1'b0, 0);
	endtask

	task automatic pick_config();
		case ($urandom_range(0, 4))
			0: set_config(32'd0, 32'd0);
			1: set_config(32'hFFFF_FFFF, 32'd4095);
			2: set_config($urandom_range(0, 32'h12000), pesig_pkg::MAX_TAG_BYTES);
			3: set_config($urandom_range(32'h100, 32'h11000), $urandom_range(0, 4095));
			default: set_config($urandom, $urandom_range(pesig_pkg::MAX_TAG_BYTES + 1, 4095));
		endcase
	endtask

	task automatic test_random_files();
		int goal;
		int files_left;
		int nbytes;
		logic [31:0] hdr, addr, len, len_end;
		logic [15:0] asn, size;
		goal = bytes_sent + 250;
		files_left = 0;
		while (bytes_sent < goal) begin
			if (files_left == 0) begin
				pick_config();
				files_left = $urandom_range(2, 4);
				src_idle = ($urandom_range(0, 3) != 0);
				snk_idle = ($urandom_range(0, 3) != 0);
			end
			// last stretch runs at full rate
			if (bytes_sent > goal - 120) begin
				src_idle = 1'b0;
				snk_idle = 1'b0;
			end
			if ($urandom_range(0, 9) < 2) begin
				nbytes = $urandom_range(2, 40);
				file_img = new[nbytes];
				foreach (file_img[i])
					file_img[i] = $urandom;
				if ($urandom_range(0, 1) != 0)
					put_le(32'd0, {16'h0, pesig_pkg::MZ_MAGIC}, 2);
				stream_image(nbytes, $urandom_range(0, 1), 16);
			end else begin
				case ($urandom_range(0, 11))
					0: hdr = 32'd0;
					1: hdr = $urandom;
					2, 3, 4: hdr = $urandom_range(1, 48);
					default: hdr = $urandom_range(64, 100) - pesig_pkg::CERT_ADDR_END;
				endcase
				len_end = hdr + pesig_pkg::CERT_LEN_END;
				case ($urandom_range(0, 19))
					0, 1: addr = 32'd0;
					2: addr = $urandom;
					default: addr = len_end + $urandom_range(0, 24) - 32'd12;
				endcase
				len = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
				asn = ($urandom_range(0, 7) == 0) ? 16'($urandom) : pesig_pkg::ASN1_MAGIC;
				case ($urandom_range(0, 9))
					0: size = 16'h0000;
					1: size = 16'hFFFF;
					default: size = $urandom_range(0, 16'hFFFF);
				endcase
				if (addr != 0 && addr < 32'd4000)
					nbytes = addr + 12 + $urandom_range(0, 6);
				else if (len_end < 32'd4000)
					nbytes = len_end + 1 + $urandom_range(0, 6);
				else
					nbytes = 70;
				if ($urandom_range(0, 9) == 0)
					nbytes = $urandom_range(2, nbytes);
				build_image(hdr, addr, len, asn, size, nbytes);
				stream_image(nbytes, $urandom_range(0, 15) != 0, 0);
			end
			files_left--;
		end
	endtask

	initial begin : run_sequence
		byte_ch.valid <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.first_byte <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= '0;
		wr_data <= '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tag_fit();
		test_magic_check();
		test_header_fields();
		test_restart();
		test_random_files();
		settle();
		if (mismatch_count == 0)
			$display("pe_signature_tag_locator verification clean");
		else
			$display("pe_signature_tag_locator verification failed");
		$finish;
	end

endmodule
